// ===== rtl/core/tdim_pkg.sv =====
`default_nettype none

package tdim_pkg;

  // Default mesh size limits
  localparam int unsigned MAX_NODES_DEF = 32'd65536;
  localparam int unsigned MAX_EDGES_DEF = 32'd131072;
  localparam int unsigned MAX_CELLS_DEF = 32'd131072;

  // Register map
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 18;

  localparam logic [CFG_INDEX_W-1:0] CFG_DOFS_PER_VERTEX = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOFS_PER_EDGE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOFS_INSIDE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMPONENTS      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NODE_COUNT      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_COUNT      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_VECTOR_MODE     = 3'd6;

  // Count limits
  localparam logic [2:0] NV_MAX = 3'd6;
  localparam logic [3:0] NE_MAX = 4'd8;
  localparam logic [3:0] NI_MAX = 4'd10;

  // Front/back queue
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [16:0] cell_number;
    logic [15:0] vertex_a;
    logic [15:0] vertex_b;
    logic [15:0] vertex_c;
    logic [16:0] side_a;
    logic [16:0] side_b;
    logic [16:0] side_c;
    logic [15:0] side_a_start;
    logic [15:0] side_b_start;
    logic [15:0] side_c_start;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  local_slot;
    logic [21:0] global_dof;
    logic        negative_sign;
    logic [2:0]  reversed_mask;
    logic        last_slot;
  } out_item_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [2:0]  nv;
    logic [3:0]  ne;
    logic [3:0]  ni;
    logic [1:0]  nc;
    logic [3:0]  groups;
    logic [16:0] nodes;
    logic [17:0] edges;
    logic        vector_mode;
  } cfg_t;

  // One classified triangle, ready for the sequencer
  typedef struct packed {
    logic [2:0][18:0] vbase;
    logic [2:0][21:0] ebase;
    logic [21:0]      ibase;
    logic [2:0]       mask;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/tdim_front.sv =====
`default_nettype none

module tdim_front #(
  parameter int unsigned MAX_CELLS = tdim_pkg::MAX_CELLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tdim_pkg::cfg_t    cfg,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire tdim_pkg::in_item_t item,
  output logic                   push,
  output tdim_pkg::entry_t       push_data,
  input  wire logic              queue_full
);

  localparam logic [31:0] CELL_LIMIT = 32'(MAX_CELLS - 1);

  // stage 1: products and reversal flags
  logic              s1_valid;
  logic [2:0][18:0]  vprod;
  logic [2:0][20:0]  sprod;
  logic [20:0]       cprod;
  logic [19:0]       eoff;
  logic [21:0]       eprod;
  logic [2:0]        mask;

  // stage 2: bases
  logic              s2_valid;
  tdim_pkg::entry_t  s2;

  logic        s1_take;
  logic        s2_take;
  logic [16:0] cell_idx;
  logic [2:0]  mask_in;

  assign s2_take    = !s2_valid || !queue_full;
  assign s1_take    = !s1_valid || s2_take;
  assign item_stall = !s1_take;
  assign push       = s2_valid && !queue_full;
  assign push_data  = s2;

  always_comb begin
    cell_idx = ({15'd0, item.cell_number} > CELL_LIMIT) ? CELL_LIMIT[16:0] : item.cell_number;
    mask_in[0] = item.side_a_start != item.vertex_a;
    mask_in[1] = item.side_b_start != item.vertex_b;
    mask_in[2] = item.side_c_start != item.vertex_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid <= item_valid;
      end
      if (s2_take) begin
        s2_valid <= s1_valid;
      end
    end
    if (s1_take && item_valid) begin
      vprod[0] <= 19'(item.vertex_a) * 19'(cfg.nv);
      vprod[1] <= 19'(item.vertex_b) * 19'(cfg.nv);
      vprod[2] <= 19'(item.vertex_c) * 19'(cfg.nv);
      sprod[0] <= 21'(item.side_a) * 21'(cfg.ne);
      sprod[1] <= 21'(item.side_b) * 21'(cfg.ne);
      sprod[2] <= 21'(item.side_c) * 21'(cfg.ne);
      cprod    <= 21'(cell_idx) * 21'(cfg.ni);
      eoff     <= 20'(cfg.nodes) * 20'(cfg.nv);
      eprod    <= 22'(cfg.edges) * 22'(cfg.ne);
      mask     <= mask_in;
    end
    if (s2_take && s1_valid) begin
      s2.vbase    <= vprod;
      s2.ebase[0] <= 22'(eoff) + 22'(sprod[0]);
      s2.ebase[1] <= 22'(eoff) + 22'(sprod[1]);
      s2.ebase[2] <= 22'(eoff) + 22'(sprod[2]);
      s2.ibase    <= 22'(eoff) + eprod + 22'(cprod);
      s2.mask     <= mask;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tdim_queue.sv =====
`default_nettype none

module tdim_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tdim_pkg::entry_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output tdim_pkg::entry_t      head
);

  localparam int unsigned AW = $clog2(tdim_pkg::QUEUE_DEPTH);

  tdim_pkg::entry_t slots [tdim_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full      = count == (AW+1)'(tdim_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tdim_back.sv =====
`default_nettype none

module tdim_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tdim_pkg::cfg_t    cfg,
  input  wire logic              queue_valid,
  input  wire tdim_pkg::entry_t  head,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output tdim_pkg::out_item_t    result
);

  typedef enum logic [1:0] {
    PH_VERT,
    PH_EDGE,
    PH_INNER
  } phase_t;

  logic             active;
  phase_t           phase;
  logic [1:0]       grp;
  logic [3:0]       j;
  logic [5:0]       slot;
  tdim_pkg::entry_t cur;

  logic        emit;
  logic        is_last;
  logic        rev;
  logic [3:0]  pos;
  logic [3:0]  half;
  logic [18:0] vbase;
  logic [21:0] ebase;
  logic [21:0] gdof;
  logic        has_any;
  phase_t      start_phase;

  assign emit = active && (!result_valid || !result_stall);

  always_comb begin
    case (grp)
      2'd0:    begin vbase = cur.vbase[0]; ebase = cur.ebase[0]; rev = cur.mask[0]; end
      2'd1:    begin vbase = cur.vbase[1]; ebase = cur.ebase[1]; rev = cur.mask[1]; end
      default: begin vbase = cur.vbase[2]; ebase = cur.ebase[2]; rev = cur.mask[2]; end
    endcase

    // mirrored position inside a reversed edge, groups of nc kept intact
    half = {1'b0, j[3:1]};
    pos  = j;
    if (rev) begin
      if (cfg.nc != 2'd2) begin
        pos = cfg.ne - 4'd1 - j;
      end else if (half < cfg.groups) begin
        pos = {cfg.groups[2:0] - 3'd1 - half[2:0], j[0]};
      end
    end

    case (phase)
      PH_VERT: begin
        gdof    = 22'(vbase) + 22'(j);
        is_last = grp == 2'd2 && j == 4'(cfg.nv) - 4'd1 && cfg.ne == '0 && cfg.ni == '0;
      end
      PH_EDGE: begin
        gdof    = ebase + 22'(pos);
        is_last = grp == 2'd2 && j == cfg.ne - 4'd1 && cfg.ni == '0;
      end
      default: begin
        gdof    = cur.ibase + 22'(j);
        is_last = j == cfg.ni - 4'd1;
      end
    endcase

    has_any = cfg.nv != '0 || cfg.ne != '0 || cfg.ni != '0;
    if (cfg.nv != '0) begin
      start_phase = PH_VERT;
    end else if (cfg.ne != '0) begin
      start_phase = PH_EDGE;
    end else begin
      start_phase = PH_INNER;
    end

    pop = queue_valid && (!active || (emit && is_last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      phase        <= PH_VERT;
      grp          <= '0;
      j            <= '0;
      slot         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      if (pop) begin
        active <= has_any;
        phase  <= start_phase;
        grp    <= '0;
        j      <= '0;
        slot   <= '0;
      end else if (emit) begin
        if (is_last) begin
          active <= 1'b0;
        end
        slot <= slot + 6'd1;
        case (phase)
          PH_VERT: begin
            if (j != 4'(cfg.nv) - 4'd1) begin
              j <= j + 4'd1;
            end else if (grp != 2'd2) begin
              grp <= grp + 2'd1;
              j   <= '0;
            end else begin
              grp   <= '0;
              j     <= '0;
              phase <= (cfg.ne != '0) ? PH_EDGE : PH_INNER;
            end
          end
          PH_EDGE: begin
            if (j != cfg.ne - 4'd1) begin
              j <= j + 4'd1;
            end else if (grp != 2'd2) begin
              grp <= grp + 2'd1;
              j   <= '0;
            end else begin
              grp   <= '0;
              j     <= '0;
              phase <= PH_INNER;
            end
          end
          default: begin
            j <= j + 4'd1;
          end
        endcase
      end
    end

    if (pop) begin
      cur <= head;
    end
    if (emit) begin
      result.local_slot    <= slot;
      result.global_dof    <= gdof;
      result.negative_sign <= phase == PH_EDGE && rev && cfg.vector_mode;
      result.reversed_mask <= cur.mask;
      result.last_slot     <= is_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/triangle_dof_index_map_core.sv =====
`default_nettype none

// Triangle local-to-global DOF map.
// item channel: one triangle per beat (valid/stall); the front stage computes
//   reversed-edge flags and the per-vertex, per-edge and interior base indices.
// result channel: one beat per local DOF, vertex DOFs first, then the edge DOFs
//   of local edges 0..2 (mirrored in component groups on reversed edges), then
//   interior DOFs; last_slot marks the final beat of a triangle.
// cfg port: cfg_we/cfg_index/cfg_data write one register per cycle; write only
//   while no triangle is in flight.
// Path: the first result beat of a triangle follows its item beat through the
//   two front stages, the queue, the sequencer and the output register.
// Output: 3*dofs_per_vertex + 3*dofs_per_edge + dofs_inside result beats per
//   triangle (clamped counts), one result per cycle from the back-end sequencer
//   while result_stall is low; a triangle with no DOFs is popped and gives no result.
// A 4-entry queue between front and back lets the front keep taking items
//   while the sequencer works; item_stall rises once the queue and both front
//   stages are full. result_stall holds the output register and the sequencer.
// Reset: clears all control state and loads the register reset values
//   (1, 0, 0, 1, 0, 0, 0).
module triangle_dof_index_map_core #(
  parameter int unsigned MAX_NODES = tdim_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = tdim_pkg::MAX_EDGES_DEF,
  parameter int unsigned MAX_CELLS = tdim_pkg::MAX_CELLS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire tdim_pkg::in_item_t                 item,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output tdim_pkg::out_item_t                     result,
  input  wire logic                               cfg_we,
  input  wire logic [tdim_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [tdim_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [31:0] NODE_LIMIT = 32'(MAX_NODES);
  localparam logic [31:0] EDGE_LIMIT = 32'(MAX_EDGES);

  // raw registers
  logic [2:0]  dofs_per_vertex;
  logic [3:0]  dofs_per_edge;
  logic [3:0]  dofs_inside;
  logic [1:0]  components;
  logic [16:0] node_count;
  logic [17:0] edge_count;
  logic        vector_mode;

  tdim_pkg::cfg_t   cfg;
  logic             push;
  tdim_pkg::entry_t push_data;
  logic             queue_full;
  logic             queue_valid;
  logic             pop;
  tdim_pkg::entry_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      dofs_per_vertex <= 3'd1;
      dofs_per_edge   <= 4'd0;
      dofs_inside     <= 4'd0;
      components      <= 2'd1;
      node_count      <= '0;
      edge_count      <= '0;
      vector_mode     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tdim_pkg::CFG_DOFS_PER_VERTEX: dofs_per_vertex <= cfg_data[2:0];
        tdim_pkg::CFG_DOFS_PER_EDGE:   dofs_per_edge   <= cfg_data[3:0];
        tdim_pkg::CFG_DOFS_INSIDE:     dofs_inside     <= cfg_data[3:0];
        tdim_pkg::CFG_COMPONENTS:      components      <= cfg_data[1:0];
        tdim_pkg::CFG_NODE_COUNT:      node_count      <= cfg_data[16:0];
        tdim_pkg::CFG_EDGE_COUNT:      edge_count      <= cfg_data[17:0];
        tdim_pkg::CFG_VECTOR_MODE:     vector_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp counts to their supported ranges
  always_comb begin
    cfg.nv = (dofs_per_vertex > tdim_pkg::NV_MAX) ? tdim_pkg::NV_MAX : dofs_per_vertex;
    cfg.ne = (dofs_per_edge > tdim_pkg::NE_MAX) ? tdim_pkg::NE_MAX : dofs_per_edge;
    cfg.ni = (dofs_inside > tdim_pkg::NI_MAX) ? tdim_pkg::NI_MAX : dofs_inside;
    case (components)
      2'd2, 2'd3: cfg.nc = 2'd2;
      default:    cfg.nc = 2'd1;
    endcase
    // whole groups of components on one edge
    cfg.groups = (cfg.nc == 2'd2) ? {1'b0, cfg.ne[3:1]} : cfg.ne;
    cfg.nodes  = ({15'd0, node_count} > NODE_LIMIT) ? NODE_LIMIT[16:0] : node_count;
    cfg.edges  = ({14'd0, edge_count} > EDGE_LIMIT) ? EDGE_LIMIT[17:0] : edge_count;
    cfg.vector_mode = vector_mode;
  end

  tdim_front #(
    .MAX_CELLS(MAX_CELLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  tdim_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_valid),
    .head      (head)
  );

  tdim_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .queue_valid  (queue_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== sim/tb_triangle_dof_index_map_core.sv =====
`timescale 1ns / 1ps

import tdim_pkg::*;

// Expected DOF beats for the triangles taken so far, plus a shadow of the registers.
class triangle_dof_scoreboard;
  logic [2:0]  reg_nv;
  logic [3:0]  reg_ne;
  logic [3:0]  reg_ni;
  logic [1:0]  reg_nc;
  logic [16:0] reg_nodes;
  logic [17:0] reg_edges;
  logic        reg_vector;
  out_item_t   dof_q[$];
  int          errors;

  function new();
    reg_nv     = 3'd1;
    reg_ne     = 4'd0;
    reg_ni     = 4'd0;
    reg_nc     = 2'd1;
    reg_nodes  = '0;
    reg_edges  = '0;
    reg_vector = 1'b0;
    errors     = 0;
  endfunction

  function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_DOFS_PER_VERTEX: reg_nv = d[2:0];
      CFG_DOFS_PER_EDGE:   reg_ne = d[3:0];
      CFG_DOFS_INSIDE:     reg_ni = d[3:0];
      CFG_COMPONENTS:      reg_nc = d[1:0];
      CFG_NODE_COUNT:      reg_nodes = d[16:0];
      CFG_EDGE_COUNT:      reg_edges = d[17:0];
      CFG_VECTOR_MODE:     reg_vector = d[0];
      default: ;
    endcase
  endfunction

  function int pending();
    return dof_q.size();
  endfunction

  function void push_dof(int k, int total, longint unsigned g, bit neg, logic [2:0] mask);
    out_item_t x;
    x.local_slot    = k[5:0];
    x.global_dof    = g[21:0];   // wraps modulo 2^22
    x.negative_sign = neg;
    x.reversed_mask = mask;
    x.last_slot     = (k == total - 1);
    dof_q.push_back(x);
  endfunction

  // Lay out every local DOF of one triangle in emission order.
  function void note_item(in_item_t it);
    longint unsigned nv, ne, ni, nc, nodes, edges, cell_idx;
    longint unsigned edge_off, inner_off, groups, pos, grp;
    longint unsigned vert[3];
    longint unsigned side[3];
    logic [2:0] mask;
    bit rev;
    int k, total;
    nv       = (reg_nv > NV_MAX) ? NV_MAX : reg_nv;
    ne       = (reg_ne > NE_MAX) ? NE_MAX : reg_ne;
    ni       = (reg_ni > NI_MAX) ? NI_MAX : reg_ni;
    nc       = (reg_nc == 2'd0) ? 1 : ((reg_nc > 2'd2) ? 2 : reg_nc);
    nodes    = (reg_nodes > MAX_NODES_DEF) ? MAX_NODES_DEF : reg_nodes;
    edges    = (reg_edges > MAX_EDGES_DEF) ? MAX_EDGES_DEF : reg_edges;
    cell_idx = (it.cell_number > MAX_CELLS_DEF - 1) ? MAX_CELLS_DEF - 1 : it.cell_number;
    edge_off  = nodes * nv;
    inner_off = edge_off + edges * ne;
    groups    = ne / nc;
    vert[0] = it.vertex_a;
    vert[1] = it.vertex_b;
    vert[2] = it.vertex_c;
    side[0] = it.side_a;
    side[1] = it.side_b;
    side[2] = it.side_c;
    mask[0] = (it.side_a_start != it.vertex_a);
    mask[1] = (it.side_b_start != it.vertex_b);
    mask[2] = (it.side_c_start != it.vertex_c);
    total = int'(3 * nv + 3 * ne + ni);
    k = 0;
    for (int v = 0; v < 3; v++) begin
      for (longint unsigned j = 0; j < nv; j++) begin
        push_dof(k, total, vert[v] * nv + j, 1'b0, mask);
        k++;
      end
    end
    for (int e = 0; e < 3; e++) begin
      rev = mask[e];
      for (longint unsigned j = 0; j < ne; j++) begin
        pos = j;
        grp = j / nc;
        // full component groups are mirrored, a trailing partial group stays put
        if (rev && grp < groups) begin
          pos = (groups - 1 - grp) * nc + j % nc;
        end
        push_dof(k, total, edge_off + side[e] * ne + pos, rev && reg_vector, mask);
        k++;
      end
    end
    for (longint unsigned j = 0; j < ni; j++) begin
      push_dof(k, total, inner_off + cell_idx * ni + j, 1'b0, mask);
      k++;
    end
  endfunction

  function void check_result(out_item_t r);
    out_item_t e;
    if (dof_q.size() == 0) begin
      $display("%0t: unexpected DOF beat slot=%0d dof=%0d neg=%0b rev=%03b last=%0b",
               $time, r.local_slot, r.global_dof, r.negative_sign, r.reversed_mask,
               r.last_slot);
      errors++;
      return;
    end
    e = dof_q.pop_front();
    if (r !== e) begin
      $display("%0t: DOF beat mismatch: expected slot=%0d dof=%0d neg=%0b rev=%03b last=%0b",
               $time, e.local_slot, e.global_dof, e.negative_sign, e.reversed_mask,
               e.last_slot);
      $display("%0t:                    actual   slot=%0d dof=%0d neg=%0b rev=%03b last=%0b",
               $time, r.local_slot, r.global_dof, r.negative_sign, r.reversed_mask,
               r.last_slot);
      errors++;
    end
  endfunction
endclass

module tb_triangle_dof_index_map_core;
  // Run bounds. The limit covers 336 triangles at up to 52 beats each with random
  // stalls on both sides, many times over.
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES   = 20;    // front stages + queue + sequencer
  localparam int unsigned IDLE_PCT        = 14;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 40;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_stall;
  in_item_t               item         = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  out_item_t              result;
  logic                   cfg_we       = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  bit                     calm         = 1'b0;  // no idling on either side while set
  int unsigned            cycle_count  = 0;
  int unsigned            random_sent  = 0;
  triangle_dof_scoreboard dof_board    = new();

  triangle_dof_index_map_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // Sample every handshake at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        dof_board.write_reg(cfg_index, cfg_data);
      end
      if (item_valid && !item_stall) begin
        dof_board.note_item(item);
      end
      if (result_valid && !result_stall) begin
        dof_board.check_result(result);
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Field values biased toward the extremes.
  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] pick17();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return 17'($urandom);
    endcase
  endfunction

  // Directed triangle: a set bit in rev gives that edge a start vertex
  // other than its local first vertex.
  function automatic in_item_t triangle_with(logic [16:0] cell_no, logic [15:0] va,
                                             logic [15:0] vb, logic [15:0] vc,
                                             logic [16:0] ea, logic [16:0] eb,
                                             logic [16:0] ec, logic [2:0] rev);
    in_item_t t;
    t.cell_number  = cell_no;
    t.vertex_a     = va;
    t.vertex_b     = vb;
    t.vertex_c     = vc;
    t.side_a       = ea;
    t.side_b       = eb;
    t.side_c       = ec;
    t.side_a_start = rev[0] ? ~va : va;
    t.side_b_start = rev[1] ? ~vb : vb;
    t.side_c_start = rev[2] ? ~vc : vc;
    return t;
  endfunction

  // Random triangle: each edge start is its own vertex half the time, else the
  // neighbor (a genuinely flipped edge) or an arbitrary vertex.
  function automatic in_item_t make_triangle();
    in_item_t    t;
    logic [15:0] v[3];
    logic [15:0] s[3];
    for (int k = 0; k < 3; k++) begin
      v[k] = pick16();
    end
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(3))
        0, 1: s[k] = v[k];
        2: s[k] = v[(k + 1) % 3];
        default: s[k] = pick16();
      endcase
    end
    t.cell_number  = pick17();
    t.vertex_a     = v[0];
    t.vertex_b     = v[1];
    t.vertex_c     = v[2];
    t.side_a       = pick17();
    t.side_b       = pick17();
    t.side_c       = pick17();
    t.side_a_start = s[0];
    t.side_b_start = s[1];
    t.side_c_start = s[2];
    return t;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(in_item_t t);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      item       <= make_triangle();  // junk payload while idle
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= t;
    do begin
      @(posedge clk);
    end while (item_stall);
    @(negedge clk);
  endtask

  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  // Only called while the block is idle.
  task automatic apply_config(int unsigned nv, int unsigned ne, int unsigned ni,
                              int unsigned nc, int unsigned nodes, int unsigned edges,
                              int unsigned vm);
    put_reg(CFG_DOFS_PER_VERTEX, nv);
    put_reg(CFG_DOFS_PER_EDGE, ne);
    put_reg(CFG_DOFS_INSIDE, ni);
    put_reg(CFG_COMPONENTS, nc);
    put_reg(CFG_NODE_COUNT, nodes);
    put_reg(CFG_EDGE_COUNT, edges);
    put_reg(CFG_VECTOR_MODE, vm);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    int unsigned nv, ne, ni, nc, nodes, edges;
    nc = $urandom_range(1, 2);
    if ($urandom_range(7) == 0) begin
      nc = $urandom_range(0, 3);
    end
    ne = (nc == 2) ? 2 * $urandom_range(0, 4) : $urandom_range(0, 8);
    if ($urandom_range(7) == 0) begin
      ne = $urandom_range(0, 15);
    end
    nv = ($urandom_range(7) == 0) ? 7 : $urandom_range(0, 6);
    ni = ($urandom_range(7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 10);
    case ($urandom_range(3))
      0: nodes = $urandom_range(3, 300);
      1: nodes = $urandom_range(0, 65536);
      2: nodes = 65536;
      default: nodes = $urandom_range(0, 131071);
    endcase
    case ($urandom_range(3))
      0: edges = $urandom_range(3, 600);
      1: edges = $urandom_range(0, 131072);
      2: edges = 131072;
      default: edges = $urandom_range(0, 262143);
    endcase
    apply_config(nv, ne, ni, nc, nodes, edges, $urandom_range(1));
  endtask

  // Wait out every expected beat, then the pipeline depth so that triangles
  // with no DOFs have left as well.
  task automatic drain();
    item_valid <= 1'b0;
    while (dof_board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: one DOF per vertex only.
    send_item(triangle_with('0, '0, '0, '0, '0, '0, '0, 3'b000));
    send_item(triangle_with('1, '1, '1, '1, '1, '1, '1, 3'b000));
    send_item(triangle_with(17'd5, 16'd1, 16'd2, 16'd3, 17'd4, 17'd5, 17'd6, 3'b111));
    drain();

    // Largest layout, vector mode: 52 beats per triangle.
    apply_config(6, 8, 10, 2, 65536, 131072, 1);
    send_item(triangle_with('0, '0, '0, '0, '0, '0, '0, 3'b000));
    send_item(triangle_with('1, '1, '1, '1, '1, '1, '1, 3'b111));
    send_item(triangle_with(17'd777, 16'd100, 16'd200, 16'd300, 17'd10, 17'd20, 17'd30,
                            3'b101));
    send_item(triangle_with(17'd1, 16'hAAAA, 16'h5555, 16'h0F0F, 17'h15555, 17'h0AAAA,
                            17'h1F0F0, 3'b010));
    drain();

    // Every count and size register beyond its range: counts and mesh sizes saturate,
    // components 3 acts as 2.
    apply_config(7, 15, 15, 3, 131071, 262143, 0);
    send_item(triangle_with('1, '1, '1, '1, '1, '1, '1, 3'b111));
    send_item(triangle_with(17'd9, 16'd4, 16'd5, 16'd6, 17'd7, 17'd8, 17'd9, 3'b000));
    drain();

    // Edge count not a multiple of components: trailing partial group stays.
    apply_config(2, 3, 1, 2, 1000, 2000, 1);
    send_item(triangle_with(17'd42, 16'd7, 16'd8, 16'd9, 17'd11, 17'd12, 17'd13, 3'b111));
    send_item(triangle_with(17'd43, 16'd7, 16'd8, 16'd9, 17'd11, 17'd12, 17'd13, 3'b000));
    drain();

    // Components 0 acts as 1.
    apply_config(1, 4, 2, 0, 50, 80, 1);
    send_item(triangle_with(17'd3, 16'd10, 16'd20, 16'd30, 17'd1, 17'd2, 17'd3, 3'b101));
    drain();

    // No DOFs at all: triangles are taken and give nothing.
    apply_config(0, 0, 0, 1, 10, 10, 1);
    send_item(triangle_with('1, '1, '1, '1, '1, '1, '1, 3'b111));
    send_item(triangle_with('0, '0, '0, '0, '0, '0, '0, 3'b000));
    send_item(make_triangle());
    drain();

    // Interior only in vector mode: no sign flag despite reversed edges.
    apply_config(0, 0, 3, 1, 65536, 131072, 1);
    send_item(triangle_with(17'd100, 16'd1, 16'd2, 16'd3, 17'd4, 17'd5, 17'd6, 3'b111));
    drain();

    // Random settings, random triangles; one stretch runs without any idling.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        calm = (random_sent >= 120) && (random_sent < 200);
        send_item(make_triangle());
        random_sent++;
      end
      calm = 1'b0;
      drain();
    end

    if (dof_board.errors == 0 && dof_board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
